[src/gf256_arithmetic_unit_core_macros.svh]
// Assertion macros shared by the GF(2^8) unit RTL.
`ifndef GF256_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define GF256_ARITHMETIC_UNIT_CORE_MACROS_SVH

// Same-cycle implication, checked on clk, disabled during reset.
`define GFAU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, disabled during reset.
`define GFAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/gfau_pkg.sv]
// Types and constants of the GF(2^8) arithmetic unit.
package gfau_pkg;

    localparam int ELEM_W  = 8;
    localparam int TOP_BIT = ELEM_W - 1;
    localparam int PROD_W  = 2 * ELEM_W - 1;

    localparam logic [ELEM_W-1:0] ELEM_ONE     = ELEM_W'(1);
    localparam logic [ELEM_W-1:0] INV_EXPONENT = ELEM_W'(254);
    // low bits of x^8+x^4+x^3+x+1, x^8 is implied
    localparam logic [ELEM_W-1:0] POLY_RESET   = 8'h1B;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_MUL = 2'd1,
        FUNC_POW = 2'd2,
        FUNC_INV = 2'd3
    } func_t;

    typedef struct packed {
        func_t             func;
        logic [ELEM_W-1:0] lhs;
        logic [ELEM_W-1:0] rhs;
        logic [ELEM_W-1:0] exponent;
    } req_t;

    typedef struct packed {
        logic ready;
        logic done;
    } seq_status_t;

endpackage

[src/gfau_mul.sv]
// Shared GF(2^8) multiplier: carry-less product and reduction.
module gfau_mul (
    input  logic [gfau_pkg::ELEM_W-1:0] a,
    input  logic [gfau_pkg::ELEM_W-1:0] b,
    input  logic [gfau_pkg::ELEM_W-1:0] poly,
    output logic [gfau_pkg::ELEM_W-1:0] p
);
    import gfau_pkg::*;

    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] red;
    logic [ELEM_W:0]   full_poly;

    assign full_poly = {1'b1, poly};

    always_comb
    begin
        prod = '0;
        for (int i = 0; i <= TOP_BIT; i++)
        begin
            if (a[i])
            begin
                prod = prod ^ (PROD_W'(b) << i);
            end
        end
        red = prod;
        // clear bits 14..8 from the top down
        for (int k = PROD_W - 1; k >= ELEM_W; k--)
        begin
            if (red[k])
            begin
                red = red ^ (PROD_W'(full_poly) << (k - ELEM_W));
            end
        end
    end

    assign p = red[ELEM_W-1:0];

endmodule

[src/gfau_seq.sv]
// Sequencer running add directly, and multiply, power and inverse on the shared multiplier.
module gfau_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  gfau_pkg::req_t               req,
    input  logic [gfau_pkg::ELEM_W-1:0]  poly,
    input  logic                         out_free,
    output gfau_pkg::seq_status_t        status,
    output logic [gfau_pkg::ELEM_W-1:0]  result
);
    import gfau_pkg::*;

    `include "gf256_arithmetic_unit_core_macros.svh"

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ACC  = 4'b0010,
        ST_SQR  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [ELEM_W-1:0] acc_reg, acc_next;
    logic [ELEM_W-1:0] sq_reg, sq_next;
    logic [ELEM_W-1:0] exp_reg, exp_next;
    logic [ELEM_W-1:0] mul_a, mul_p;

    // acc step: acc*sq, square step: sq*sq
    assign mul_a = (state_reg == ST_SQR) ? sq_reg : acc_reg;

    gfau_mul u_mul (
        .a    (mul_a),
        .b    (sq_reg),
        .poly (poly),
        .p    (mul_p)
    );

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        exp_next   = exp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_ACC;
                    case (req.func)
                        FUNC_ADD:
                        begin
                            acc_next   = req.lhs ^ req.rhs;
                            state_next = ST_DONE;
                        end
                        FUNC_MUL:
                        begin
                            // one acc step: lhs * rhs
                            acc_next = req.lhs;
                            sq_next  = req.rhs;
                            exp_next = ELEM_ONE;
                        end
                        FUNC_POW:
                        begin
                            acc_next = ELEM_ONE;
                            sq_next  = req.lhs;
                            exp_next = req.exponent;
                        end
                        default:
                        begin
                            acc_next = ELEM_ONE;
                            sq_next  = req.lhs;
                            exp_next = INV_EXPONENT;
                        end
                    endcase
                end
            end
            ST_ACC:
            begin
                if (exp_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    if (exp_reg[0])
                    begin
                        acc_next = mul_p;
                    end
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                sq_next    = mul_p;
                exp_next   = exp_reg >> 1;
                state_next = ST_ACC;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sq_reg  <= sq_next;
        exp_reg <= exp_next;
    end

    assign status.ready = (state_reg == ST_IDLE);
    assign status.done  = (state_reg == ST_DONE) && out_free;
    assign result       = acc_reg;

    `GFAU_ASSERT_NOW(a_done_not_ready, status.done, !status.ready,
        "result handed off while sequencer reports ready")
    `GFAU_ASSERT_NEXT(a_busy_after_start, start && status.ready, !status.ready,
        "sequencer still ready after taking a request")
    `GFAU_ASSERT_NEXT(a_exp_shift, state_reg == ST_SQR, exp_reg == ($past(exp_reg) >> 1),
        "exponent not shifted by square step")
    `GFAU_ASSERT_NEXT(a_exp_zero_done, (state_reg == ST_ACC) && (exp_reg == '0),
        state_reg == ST_DONE, "exhausted exponent did not finish")

endmodule

[src/gf256_arithmetic_unit_core.sv]
// Top level of the GF(2^8) arithmetic unit: stream ports, config and output register.
//
//  channel  | dir | payload                                   | request taken when
//  ---------+-----+-------------------------------------------+-------------------------
//  s_*      | in  | tuser: func; tdata: lhs, rhs, exponent    | s_tvalid && s_tready
//  m_*      | out | tdata: result                             | m_tvalid && m_tready
//  cfg_*    | in  | cfg_wr_data: reduction polynomial (9 bit) | cfg_wr_en
//
// Power and inverse step through the exponent on the single shared multiplier:
// per bit an accumulate step (multiply by the square when the bit is set) and a
// square step. Multiply runs a single accumulate step, lhs times rhs, and add
// needs no multiply.
// s_tready is high only while the sequencer is idle; a finished result waits in
// the output register, so the next request is taken while m_tready is low.
// Reset restores the polynomial to x^8+x^4+x^3+x+1 and empties the output.
module gf256_arithmetic_unit_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // [7:0] lhs, [15:8] rhs, [23:16] exponent
    input  logic [1:0]  s_tuser,     // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [7:0] result
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data
);
    import gfau_pkg::*;

    // bit 8 of the register is always treated as set, so only the low bits are kept
    logic [ELEM_W-1:0] poly_reg;
    logic              out_valid_reg, out_valid_next;
    logic [ELEM_W-1:0] out_data_reg, out_data_next;

    req_t              req;
    seq_status_t       status;
    logic [ELEM_W-1:0] seq_result;
    logic              out_free;
    logic              start;

    assign req.func     = func_t'(s_tuser);
    assign req.lhs      = s_tdata[7:0];
    assign req.rhs      = s_tdata[15:8];
    assign req.exponent = s_tdata[23:16];

    assign s_tready = status.ready;
    assign start    = s_tvalid && status.ready;
    // output slot free if empty or being drained this cycle
    assign out_free = !out_valid_reg || m_tready;

    gfau_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .poly     (poly_reg),
        .out_free (out_free),
        .status   (status),
        .result   (seq_result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (status.done)
        begin
            out_valid_next = 1'b1;
            out_data_next  = seq_result;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg      <= POLY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                poly_reg <= cfg_wr_data[ELEM_W-1:0];
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[sim/gf256_arithmetic_unit_core_tb.sv]
// Self-checking testbench for the GF(2^8) arithmetic unit: directed table, then random phases.
module gf256_arithmetic_unit_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gfau_pkg::*;

    // Worst request is power or inverse with a full-length exponent; the settling
    // time is sized from it.
    localparam int SETTLE_CYCLES   = 40;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int MAX_REPORTS     = 10;
    localparam int NUM_PHASES      = 8;
    localparam int REQS_PER_PHASE  = 62;
    localparam int NUM_DIRECTED    = 20;

    // Flow-control mixes: percent of cycles the sender idles / the receiver stalls.
    typedef enum int {
        FLOW_OPEN      = 0,
        FLOW_TX_IDLE   = 1,
        FLOW_RX_STALL  = 2,
        FLOW_BOTH      = 3
    } flow_mode_t;

    // One row of the directed table. known = 1 means the expected element is
    // written in the row; otherwise it comes from the field arithmetic below.
    typedef struct packed {
        func_t       func;
        logic [7:0]  lhs;
        logic [7:0]  rhs;
        logic [7:0]  exponent;
        logic        known;
        logic [7:0]  value;
    } dir_row_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        s_tvalid     = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata      = '0;    // [7:0] lhs, [15:8] rhs, [23:16] exponent
    logic [1:0]  s_tuser      = FUNC_ADD; // [1:0] func
    logic        m_tvalid;
    logic        m_tready     = 1'b0;
    logic [7:0]  m_tdata;              // [7:0] result
    logic        cfg_wr_en    = 1'b0;
    logic [8:0]  cfg_wr_data  = '0;

    // Scoreboard and bookkeeping.
    logic [7:0]  expected_results [$];
    logic [8:0]  poly_model       = 9'd283;   // mirror of the reduction register
    int          tx_idle_pct      = 0;
    int          rx_stall_pct     = 0;
    int          mismatches       = 0;
    int          results_checked  = 0;
    int          reqs_sent        = 0;
    int          cycle_count      = 0;

    logic [8:0]  phase_poly [NUM_PHASES];

    // Directed requests, all under the reset polynomial x^8+x^4+x^3+x+1.
    dir_row_t dir_rows [NUM_DIRECTED] = '{
        // add: extremes, and exponent ignored
        '{FUNC_ADD, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00},
        '{FUNC_ADD, 8'hFF, 8'hFF, 8'h00, 1'b1, 8'h00},
        '{FUNC_ADD, 8'hFF, 8'h00, 8'h00, 1'b1, 8'hFF},
        '{FUNC_ADD, 8'hA5, 8'h5A, 8'hFF, 1'b1, 8'hFF},
        // multiply: zero, identity, full operands, x^7 * x hits the reduction
        '{FUNC_MUL, 8'h00, 8'hFF, 8'hFF, 1'b1, 8'h00},
        '{FUNC_MUL, 8'hFF, 8'h01, 8'h00, 1'b1, 8'hFF},
        '{FUNC_MUL, 8'hFF, 8'hFF, 8'h00, 1'b0, 8'h00},
        '{FUNC_MUL, 8'h80, 8'h02, 8'h00, 1'b1, POLY_RESET},
        '{FUNC_MUL, 8'h53, 8'hCA, 8'h00, 1'b0, 8'h00},
        // power: zero exponent gives one even for a zero base; rhs ignored
        '{FUNC_POW, 8'h00, 8'h00, 8'h00, 1'b1, ELEM_ONE},
        '{FUNC_POW, 8'hFF, 8'hFF, 8'h00, 1'b1, ELEM_ONE},
        '{FUNC_POW, 8'h00, 8'h00, 8'hFF, 1'b1, 8'h00},
        '{FUNC_POW, 8'h01, 8'hFF, 8'hFF, 1'b1, ELEM_ONE},
        '{FUNC_POW, 8'h02, 8'h00, 8'h01, 1'b1, 8'h02},
        '{FUNC_POW, 8'h03, 8'h00, 8'hFF, 1'b0, 8'h00},
        '{FUNC_POW, 8'hFF, 8'h00, 8'h80, 1'b0, 8'h00},
        // inverse: zero maps to zero; rhs and exponent ignored
        '{FUNC_INV, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00},
        '{FUNC_INV, 8'h01, 8'hFF, 8'hFF, 1'b1, ELEM_ONE},
        '{FUNC_INV, 8'hFF, 8'h00, 8'h00, 1'b0, 8'h00},
        '{FUNC_INV, 8'h53, 8'h00, 8'h00, 1'b0, 8'h00}
    };

    gf256_arithmetic_unit_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------------
    // Field arithmetic
    // ---------------------------------------------------------------------

    // Carry-less product, then reduction by x^8 plus the low 8 register bits.
    // Bit 8 of the register is not looked at: x^8 is always present.
    function automatic logic [7:0] gf_product(logic [7:0] a, logic [7:0] b, logic [8:0] poly);
        logic [14:0] prod;
        logic [14:0] modulus;
        prod    = '0;
        modulus = {6'b0, 1'b1, poly[7:0]};
        for (int i = 0; i < 8; i++)
        begin
            if (a[i])
                prod ^= 15'(b) << i;
        end
        for (int i = 14; i >= 8; i--)
        begin
            if (prod[i])
                prod ^= modulus << (i - 8);
        end
        return prod[7:0];
    endfunction

    // Square-and-multiply, LSB first; exponent 0 leaves the accumulator at one.
    function automatic logic [7:0] gf_power(logic [7:0] base, logic [7:0] e, logic [8:0] poly);
        logic [7:0] acc;
        logic [7:0] sq;
        acc = ELEM_ONE;
        sq  = base;
        for (int i = 0; i < 8; i++)
        begin
            if (e[i])
                acc = gf_product(acc, sq, poly);
            sq = gf_product(sq, sq, poly);
        end
        return acc;
    endfunction

    function automatic logic [7:0] gf_eval(func_t f, logic [7:0] a, logic [7:0] b,
                                           logic [7:0] e, logic [8:0] poly);
        case (f)
            FUNC_ADD: return a ^ b;
            FUNC_MUL: return gf_product(a, b, poly);
            FUNC_POW: return gf_power(a, e, poly);
            default:  return gf_power(a, INV_EXPONENT, poly);
        endcase
    endfunction

    // Operands biased toward zero, one and all-ones.
    function automatic logic [7:0] pick_elem();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    // Exponents biased toward the edges and the inverse exponent.
    function automatic logic [7:0] pick_exponent();
        case ($urandom_range(11))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return INV_EXPONENT;
            3:       return 8'hFF;
            4:       return 8'($urandom_range(15));
            default: return 8'($urandom());
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------------

    // Offer one request; returns on the edge that takes it. tvalid stays high
    // when the next request follows without a gap, so it never drops and
    // rises in the same step.
    task automatic send_request(func_t f, logic [7:0] a, logic [7:0] b, logic [7:0] e,
                                logic known, logic [7:0] known_val);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {e, b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(known ? known_val : gf_eval(f, a, b, e, poly_model));
        reqs_sent++;
    endtask

    // Drop tvalid, let every result come back, then give the core time to settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only ever called with the core idle.
    task automatic write_poly(logic [8:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        poly_model   = value;
        @(posedge clk);
    endtask

    task automatic set_flow(flow_mode_t mode);
        case (mode)
            FLOW_OPEN:     begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            FLOW_TX_IDLE:  begin tx_idle_pct = 69; rx_stall_pct = 0;  end
            FLOW_RX_STALL: begin tx_idle_pct = 0;  rx_stall_pct = 69; end
            default:       begin tx_idle_pct = 14; rx_stall_pct = 14; end
        endcase
    endtask

    // ---------------------------------------------------------------------
    // Result side: random backpressure and in-order compare
    // ---------------------------------------------------------------------

    always @(posedge clk)
    begin
        logic [7:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: result 0x%02h with no request outstanding", m_tdata);
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (m_tdata !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("ERROR: result #%0d expected 0x%02h got 0x%02h (poly 0x%03h)",
                                 results_checked, want, m_tdata, poly_model);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------

    initial
    begin
        func_t f;
        // Polynomials per random phase: the reset value, both ends of the range,
        // one with bit 8 clear (x^8 still implied), another irreducible one, random, reset again.
        phase_poly[0] = 9'd283;
        phase_poly[1] = 9'h100;
        phase_poly[2] = 9'h1FF;
        phase_poly[3] = 9'h0FF;
        phase_poly[4] = 9'h11D;
        phase_poly[5] = 9'($urandom_range(511, 256));
        phase_poly[6] = 9'($urandom_range(511));
        phase_poly[7] = 9'd283;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed table under the reset polynomial, no flow control.
        set_flow(FLOW_OPEN);
        for (int r = 0; r < NUM_DIRECTED; r++)
            send_request(dir_rows[r].func, dir_rows[r].lhs, dir_rows[r].rhs,
                         dir_rows[r].exponent, dir_rows[r].known, dir_rows[r].value);
        drain_results();

        // Random phases: polynomial written each time, flow mixes rotate.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_poly(phase_poly[p]);
            set_flow(flow_mode_t'(p % 4));
            for (int n = 0; n < REQS_PER_PHASE; n++)
            begin
                f = func_t'($urandom_range(3));
                send_request(f, pick_elem(), pick_elem(), pick_exponent(), 1'b0, 8'h00);
            end
            drain_results();
        end

        if (expected_results.size() != 0)
        begin
            mismatches++;
            $display("ERROR: %0d results never arrived", expected_results.size());
        end

        $display("Summary: %0d requests (directed table plus random add/mul/pow/inv) over %0d",
                 reqs_sent, NUM_PHASES + 1);
        $display("  reduction polynomials and four flow-control mixes; %0d results compared",
                 results_checked);
        if (mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
